// ----- rtl/slec_pkg.sv -----
`timescale 1ns / 1ps
package slec_pkg;

  localparam int CAPACITY_DEF = 128;
  localparam int POS_W        = 7;
  localparam int VAL_W        = 32;
  localparam int CNT_OUT_W    = 8;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_UPDATE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  // classified request as it travels from front to back
  typedef struct packed {
    op_t               op;
    logic [POS_W-1:0]  pos;
    logic [VAL_W-1:0]  val;
    status_t           status;
  } cmd_t;

endpackage

// ----- rtl/sequential_list_engine_core.sv -----
`timescale 1ns / 1ps
// channel   | handshake                | payload
// ----------+--------------------------+---------------------------------------------
// request   | start, busy (accept when | op, position, value
//           | start high and busy low) |
// result    | result_valid (one cycle) | status, found_position, entry_count, list_empty
//
// one request at a time: busy stays high from accept through the result cycle,
// so the next request can be accepted in the cycle after the result.
// update and error cases put the result out without a walk; insert, delete
// and search can walk the entry memory through its single read port, one entry per
// cycle, before the result goes out; a walk reads at most CAPACITY entries.
// synchronous reset empties the list; entry memory is not cleared.
// the result strobe cannot be stalled by the receiver.
module sequential_list_engine_core
  import slec_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           op,
  input  logic [POS_W-1:0]     position,
  input  logic [VAL_W-1:0]     value,
  output logic                 result_valid,
  output logic [2:0]           status,
  output logic [POS_W-1:0]     found_position,
  output logic [CNT_OUT_W-1:0] entry_count,
  output logic                 list_empty
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic          push;
  cmd_t          push_cmd;
  logic          q_valid;
  cmd_t          q_cmd;
  logic          q_pop;
  logic [CW-1:0] count;

  slec_front #(
    .CAPACITY(CAPACITY)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .op      (op),
    .position(position),
    .value   (value),
    .count   (count),
    .done    (result_valid),
    .push    (push),
    .cmd     (push_cmd)
  );

  slec_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (q_pop),
    .valid   (q_valid),
    .head    (q_cmd)
  );

  slec_back #(
    .CAPACITY(CAPACITY)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop),
    .count         (count),
    .done          (result_valid),
    .status        (status),
    .found_position(found_position),
    .entry_count   (entry_count),
    .list_empty    (list_empty)
  );

endmodule

// ----- rtl/slec_ram.sv -----
`timescale 1ns / 1ps
module slec_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/slec_front.sv -----
`timescale 1ns / 1ps
module slec_front
  import slec_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     op,
  input  logic [POS_W-1:0]               position,
  input  logic [VAL_W-1:0]               value,
  input  logic [$clog2(CAPACITY+1)-1:0]  count,
  input  logic                           done,
  output logic                           push,
  output cmd_t                           cmd
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  logic [CMPW-1:0] cx;
  logic [CMPW-1:0] posx;
  op_t             op_in;
  status_t         st;

  assign cx    = CMPW'(count);
  assign posx  = CMPW'(position);
  assign op_in = op_t'(op);
  assign push  = start && !busy;

  always_comb begin
    st = ST_OK;
    case (op_in)
      OP_INSERT: begin
        if (cx >= CMPW'(CAPACITY)) begin
          st = ST_FULL;
        end else if (posx > cx) begin
          st = ST_BADPOS;
        end
      end
      OP_SEARCH: begin
        if (cx == '0) begin
          st = ST_EMPTY;
        end
      end
      OP_DELETE, OP_UPDATE: begin
        if (cx == '0) begin
          st = ST_EMPTY;
        end else if (posx >= cx) begin
          st = ST_BADPOS;
        end
      end
      default: st = ST_OK;
    endcase
  end

  always_comb begin
    cmd.op     = op_in;
    cmd.pos    = position;
    cmd.val    = value;
    cmd.status = st;
  end

  // one transaction outstanding until its result goes out
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (push) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

endmodule

// ----- rtl/slec_queue.sv -----
`timescale 1ns / 1ps
module slec_queue
  import slec_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic valid,
  output cmd_t head
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;

  assign valid   = (fill != 2'd0);
  assign head    = slots[rd_ptr];
  assign do_push = push && (fill != 2'd2);
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ----- rtl/slec_back.sv -----
`timescale 1ns / 1ps
module slec_back
  import slec_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  input  cmd_t                           q_cmd,
  output logic                           q_pop,
  output logic [$clog2(CAPACITY+1)-1:0]  count,
  output logic                           done,
  output logic [2:0]                     status,
  output logic [POS_W-1:0]               found_position,
  output logic [CNT_OUT_W-1:0]           entry_count,
  output logic                           list_empty
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int AW   = $clog2(CAPACITY);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FIN
  } state_t;

  state_t          state;
  cmd_t            cmd;
  logic [AW-1:0]   rp;
  logic [AW-1:0]   last_addr;
  logic [AW-1:0]   raddr_q;
  logic [AW-1:0]   found;
  logic            more;
  logic            rvalid;
  logic            commit;
  status_t         res_status;

  logic            we;
  logic [AW-1:0]   waddr;
  logic [VAL_W-1:0] wdata;
  logic            re;
  logic [VAL_W-1:0] rdata;
  logic            hit;

  logic [CMPW-1:0] cx;
  logic [CMPW-1:0] qpos;
  logic [CMPW-1:0] cpos;

  assign cx    = CMPW'(count);
  assign qpos  = CMPW'(q_cmd.pos);
  assign cpos  = CMPW'(cmd.pos);
  assign q_pop = (state == S_IDLE) && q_valid;
  assign hit   = rvalid && (rdata == cmd.val);

  slec_ram #(
    .WIDTH(VAL_W),
    .DEPTH(CAPACITY)
  ) u_entries (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(rp),
    .rdata(rdata)
  );

  // shifts move one entry per cycle: read at rp, write the previous read one slot over
  always_comb begin
    we    = 1'b0;
    waddr = raddr_q;
    wdata = cmd.val;
    re    = 1'b0;
    case (state)
      S_IDLE: begin
        if (q_valid && q_cmd.op == OP_UPDATE && q_cmd.status == ST_OK) begin
          we    = 1'b1;
          waddr = AW'(qpos);
          wdata = q_cmd.val;
        end
      end
      S_WALK: begin
        re = more;
        if (rvalid && cmd.op != OP_SEARCH) begin
          we    = 1'b1;
          wdata = rdata;
          if (cmd.op == OP_INSERT) begin
            waddr = raddr_q + 1'b1;
          end else begin
            waddr = raddr_q - 1'b1;
          end
        end
      end
      S_FIN: begin
        if (commit && cmd.op == OP_INSERT) begin
          we    = 1'b1;
          waddr = AW'(cpos);
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      done   <= 1'b0;
      more   <= 1'b0;
      rvalid <= 1'b0;
      commit <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cmd        <= q_cmd;
            commit     <= 1'b0;
            found      <= '0;
            rvalid     <= 1'b0;
            res_status <= q_cmd.status;
            state      <= S_FIN;
            if (q_cmd.status == ST_OK) begin
              case (q_cmd.op)
                OP_INSERT: begin
                  if (qpos == cx) begin
                    commit <= 1'b1;
                  end else begin
                    rp        <= AW'(cx - 1'b1);
                    last_addr <= AW'(qpos);
                    more      <= 1'b1;
                    state     <= S_WALK;
                  end
                end
                OP_DELETE: begin
                  if (qpos == cx - 1'b1) begin
                    commit <= 1'b1;
                  end else begin
                    rp        <= AW'(qpos + 1'b1);
                    last_addr <= AW'(cx - 1'b1);
                    more      <= 1'b1;
                    state     <= S_WALK;
                  end
                end
                OP_SEARCH: begin
                  res_status <= ST_NOTFOUND;
                  if (qpos < cx) begin
                    rp        <= AW'(qpos);
                    last_addr <= AW'(cx - 1'b1);
                    more      <= 1'b1;
                    state     <= S_WALK;
                  end
                end
                default: begin
                  commit <= 1'b0;
                end
              endcase
            end
          end
        end
        S_WALK: begin
          rvalid  <= more;
          raddr_q <= rp;
          if (more) begin
            if (rp == last_addr) begin
              more <= 1'b0;
            end else if (cmd.op == OP_INSERT) begin
              rp <= rp - 1'b1;
            end else begin
              rp <= rp + 1'b1;
            end
          end
          if (cmd.op == OP_SEARCH && hit) begin
            res_status <= ST_OK;
            found      <= raddr_q;
            more       <= 1'b0;
            rvalid     <= 1'b0;
            state      <= S_FIN;
          end else if (!more && !rvalid) begin
            commit <= (cmd.op != OP_SEARCH);
            state  <= S_FIN;
          end
        end
        S_FIN: begin
          if (commit && cmd.op == OP_INSERT) begin
            count <= CW'(count + 1'b1);
          end else if (commit && cmd.op == OP_DELETE) begin
            count <= CW'(count - 1'b1);
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign status         = res_status;
  assign found_position = POS_W'(found);
  assign entry_count    = CNT_OUT_W'(count);
  assign list_empty     = (count == '0);

endmodule

// ----- verif/tb_sequential_list_engine_core.sv -----
`timescale 1ns / 1ps
module tb_sequential_list_engine_core;
  import slec_pkg::*;

  localparam int CAPACITY    = CAPACITY_DEF;
  localparam int STALL_LIMIT = 2000;

  typedef enum {MIX_OPS, GROW, SHRINK} traffic_t;

  typedef struct packed {
    status_t              st;
    logic [POS_W-1:0]     found;
    logic [CNT_OUT_W-1:0] cnt;
    logic                 empty;
  } list_result_t;

  typedef struct packed {
    op_t                  op;
    logic [POS_W-1:0]     pos;
    logic [VAL_W-1:0]     val;
    logic                 typed;
    status_t              st;
    logic [POS_W-1:0]     found;
    logic [CNT_OUT_W-1:0] cnt;
  } dir_row_t;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [1:0]           op;
  logic [POS_W-1:0]     position;
  logic [VAL_W-1:0]     value;
  logic                 result_valid;
  logic [2:0]           status;
  logic [POS_W-1:0]     found_position;
  logic [CNT_OUT_W-1:0] entry_count;
  logic                 list_empty;

  // typed-in expectation riding along with the current directed transaction
  logic                 row_typed;
  list_result_t         row_want;

  logic [VAL_W-1:0] list_mirror [0:CAPACITY-1];
  int               mirror_count;
  list_result_t     pending_results[$];

  int accepts;
  int results_seen;
  int mismatches;
  int stall_cycles;
  int peak_count;
  int op_hits [0:3];
  int status_hits [0:7];

  dir_row_t dir_rows [0:24];

  sequential_list_engine_core uut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .op             (op),
    .position       (position),
    .value          (value),
    .result_valid   (result_valid),
    .status         (status),
    .found_position (found_position),
    .entry_count    (entry_count),
    .list_empty     (list_empty)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("mismatch at %0t, result %0d, %s: got %0h expected %0h",
             $realtime, results_seen, what, got, want);
  endtask

  // applies one request to the mirror list and returns the result it gives
  task automatic predict_list_op(input op_t o, input logic [POS_W-1:0] p,
                                 input logic [VAL_W-1:0] v, output list_result_t r);
    int i;
    int pi;
    pi = p;
    r = '0;
    r.st = ST_OK;
    case (o)
      OP_INSERT: begin
        if (mirror_count >= CAPACITY) r.st = ST_FULL;
        else if (pi > mirror_count) r.st = ST_BADPOS;
        else begin
          for (i = mirror_count; i > pi; i--) list_mirror[i] = list_mirror[i-1];
          list_mirror[pi] = v;
          mirror_count++;
        end
      end
      OP_DELETE: begin
        if (mirror_count == 0) r.st = ST_EMPTY;
        else if (pi >= mirror_count) r.st = ST_BADPOS;
        else begin
          for (i = pi; i + 1 < mirror_count; i++) list_mirror[i] = list_mirror[i+1];
          mirror_count--;
        end
      end
      OP_SEARCH: begin
        if (mirror_count == 0) r.st = ST_EMPTY;
        else begin
          r.st = ST_NOTFOUND;
          for (i = pi; i < mirror_count; i++) begin
            if (list_mirror[i] == v) begin
              r.st = ST_OK;
              r.found = i[POS_W-1:0];
              break;
            end
          end
        end
      end
      default: begin
        if (mirror_count == 0) r.st = ST_EMPTY;
        else if (pi >= mirror_count) r.st = ST_BADPOS;
        else list_mirror[pi] = v;
      end
    endcase
    r.cnt = mirror_count[CNT_OUT_W-1:0];
    r.empty = (mirror_count == 0);
  endtask

  always @(posedge clk) begin : monitor
    list_result_t want;
    list_result_t calc;
    if (!rst) begin
      if (result_valid === 1'b1) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("result with no transaction pending", status, 0);
        end else begin
          want = pending_results.pop_front();
          if (status !== want.st) report_mismatch("status", status, want.st);
          if (found_position !== want.found)
            report_mismatch("found_position", found_position, want.found);
          if (entry_count !== want.cnt) report_mismatch("entry_count", entry_count, want.cnt);
          if (list_empty !== want.empty) report_mismatch("list_empty", list_empty, want.empty);
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        predict_list_op(op_t'(op), position, value, calc);
        pending_results.push_back(row_typed ? row_want : calc);
        accepts++;
        op_hits[op]++;
        status_hits[calc.st]++;
        if (mirror_count > peak_count) peak_count = mirror_count;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start === 1'b1 && busy === 1'b0) || result_valid === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d idle cycles", stall_cycles);
      $display("tb_sequential_list_engine_core failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic issue(input op_t o, input logic [POS_W-1:0] p, input logic [VAL_W-1:0] v,
                       input logic typed, input list_result_t want);
    int seen;
    seen = accepts;
    start     <= 1'b1;
    op        <= o;
    position  <= p;
    value     <= v;
    row_typed <= typed;
    row_want  <= want;
    do @(negedge clk); while (accepts == seen);
  endtask

  task automatic maybe_pause(input int pct);
    if ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  task automatic pick_request(input traffic_t mode, output op_t o,
                              output logic [POS_W-1:0] p, output logic [VAL_W-1:0] v);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      GROW:    o = (r < 85) ? OP_INSERT : op_t'($urandom_range(0, 3));
      SHRINK:  o = (r < 85) ? OP_DELETE : op_t'($urandom_range(0, 3));
      default: o = op_t'($urandom_range(0, 3));
    endcase
    r = $urandom_range(0, 99);
    if (r < 20) p = POS_W'($urandom_range(0, 127));
    else if (o == OP_INSERT)
      p = POS_W'($urandom_range(0, (mirror_count > 127) ? 127 : mirror_count));
    else p = (mirror_count == 0) ? '0 : POS_W'($urandom_range(0, mirror_count - 1));
    r = $urandom_range(0, 99);
    if (r < 40 && mirror_count > 0) begin
      v = list_mirror[$urandom_range(0, mirror_count - 1)];
    end else if (r < 50) begin
      // small pool so that duplicates build up and first-match matters
      v = $urandom_range(0, 7);
    end else if (r < 60) begin
      case ($urandom_range(0, 3))
        0:       v = '0;
        1:       v = 32'h8000_0000;
        2:       v = 32'h7fff_ffff;
        default: v = '1;
      endcase
    end else begin
      v = $urandom;
    end
  endtask

  // for grow and shrink, items counts the transactions issued once full or empty
  task automatic run_traffic(input traffic_t mode, input int items, input int idle_pct);
    op_t              o;
    logic [POS_W-1:0] p;
    logic [VAL_W-1:0] v;
    int               n;
    int               done;
    int               cur_pct;
    n = 0;
    done = 0;
    cur_pct = idle_pct;
    while (done < items && n < 600) begin
      if (n % 32 == 0) cur_pct = ($urandom_range(0, 2) == 0) ? 0 : idle_pct;
      maybe_pause(cur_pct);
      pick_request(mode, o, p, v);
      issue(o, p, v, 1'b0, '0);
      n++;
      if (mode == MIX_OPS || (mode == GROW && mirror_count == CAPACITY) ||
          (mode == SHRINK && mirror_count == 0))
        done++;
    end
  endtask

  initial begin
    list_result_t typed_want;
    rst = 1'b1;
    start = 1'b0;
    op = OP_INSERT;
    position = '0;
    value = '0;
    row_typed = 1'b0;
    row_want = '0;
    mirror_count = 0;
    accepts = 0;
    results_seen = 0;
    mismatches = 0;
    stall_cycles = 0;
    peak_count = 0;
    foreach (op_hits[k]) op_hits[k] = 0;
    foreach (status_hits[k]) status_hits[k] = 0;

    // list after some ok insert and update rows is noted on the right
    dir_rows = '{
      '{OP_DELETE, 7'd0,   32'h0000_0000, 1'b1, ST_EMPTY,    7'd0, 8'd0},
      '{OP_SEARCH, 7'd0,   32'h0000_0005, 1'b1, ST_EMPTY,    7'd0, 8'd0},
      '{OP_UPDATE, 7'd0,   32'h0000_0005, 1'b1, ST_EMPTY,    7'd0, 8'd0},
      '{OP_INSERT, 7'd1,   32'h0000_0007, 1'b1, ST_BADPOS,   7'd0, 8'd0},
      '{OP_INSERT, 7'd127, 32'h0000_0007, 1'b1, ST_BADPOS,   7'd0, 8'd0},
      '{OP_INSERT, 7'd0,   32'h8000_0000, 1'b1, ST_OK,       7'd0, 8'd1}, // min
      '{OP_INSERT, 7'd1,   32'h7fff_ffff, 1'b1, ST_OK,       7'd0, 8'd2}, // min max
      '{OP_INSERT, 7'd0,   32'hffff_ffff, 1'b1, ST_OK,       7'd0, 8'd3}, // -1 min max
      '{OP_SEARCH, 7'd0,   32'hffff_ffff, 1'b1, ST_OK,       7'd0, 8'd3},
      '{OP_SEARCH, 7'd1,   32'h7fff_ffff, 1'b1, ST_OK,       7'd2, 8'd3},
      '{OP_SEARCH, 7'd1,   32'hffff_ffff, 1'b1, ST_NOTFOUND, 7'd0, 8'd3},
      '{OP_SEARCH, 7'd3,   32'h8000_0000, 1'b1, ST_NOTFOUND, 7'd0, 8'd3},
      '{OP_SEARCH, 7'd127, 32'h8000_0000, 1'b1, ST_NOTFOUND, 7'd0, 8'd3},
      '{OP_UPDATE, 7'd3,   32'h0000_0000, 1'b1, ST_BADPOS,   7'd0, 8'd3},
      '{OP_UPDATE, 7'd127, 32'h0000_0000, 1'b1, ST_BADPOS,   7'd0, 8'd3},
      '{OP_UPDATE, 7'd1,   32'h0000_0000, 1'b1, ST_OK,       7'd0, 8'd3}, // -1 0 max
      '{OP_INSERT, 7'd3,   32'h1234_5678, 1'b0, ST_OK,       7'd0, 8'd0}, // append
      '{OP_INSERT, 7'd2,   32'h0000_0000, 1'b0, ST_OK,       7'd0, 8'd0}, // -1 0 0 max x
      '{OP_SEARCH, 7'd0,   32'h0000_0000, 1'b0, ST_OK,       7'd0, 8'd0},
      '{OP_SEARCH, 7'd2,   32'h0000_0000, 1'b0, ST_OK,       7'd0, 8'd0},
      '{OP_DELETE, 7'd5,   32'h0000_0000, 1'b1, ST_BADPOS,   7'd0, 8'd5},
      '{OP_DELETE, 7'd127, 32'hffff_ffff, 1'b1, ST_BADPOS,   7'd0, 8'd5},
      '{OP_DELETE, 7'd0,   32'h0000_0000, 1'b0, ST_OK,       7'd0, 8'd0},
      '{OP_DELETE, 7'd3,   32'h0000_0000, 1'b0, ST_OK,       7'd0, 8'd0},
      '{OP_SEARCH, 7'd0,   32'h1234_5678, 1'b0, ST_OK,       7'd0, 8'd0}
    };

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[k]) begin
      typed_want.st    = dir_rows[k].st;
      typed_want.found = dir_rows[k].found;
      typed_want.cnt   = dir_rows[k].cnt;
      typed_want.empty = (dir_rows[k].cnt == 0);
      maybe_pause(25);
      issue(dir_rows[k].op, dir_rows[k].pos, dir_rows[k].val, dir_rows[k].typed, typed_want);
    end
    hold_until_drained();

    run_traffic(MIX_OPS, 20, 20);
    run_traffic(GROW, 6, 10);
    hold_until_drained();
    run_traffic(MIX_OPS, 10, 30);
    run_traffic(SHRINK, 4, 15);
    hold_until_drained();
    run_traffic(GROW, 0, 10);
    run_traffic(MIX_OPS, 30, 0);

    start <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
    repeat (CAPACITY + 16) @(negedge clk);

    $display("%0d transactions: %0d insert, %0d delete, %0d search, %0d update; peak count %0d",
             accepts, op_hits[OP_INSERT], op_hits[OP_DELETE], op_hits[OP_SEARCH],
             op_hits[OP_UPDATE], peak_count);
    $display("statuses: ok %0d, full %0d, empty %0d, bad position %0d, not found %0d",
             status_hits[ST_OK], status_hits[ST_FULL], status_hits[ST_EMPTY],
             status_hits[ST_BADPOS], status_hits[ST_NOTFOUND]);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb_sequential_list_engine_core passed");
    end else begin
      $display("tb_sequential_list_engine_core failed");
    end
    $finish;
  end

endmodule

// ----- sequential_list_engine_core.f -----
rtl/slec_pkg.sv
rtl/slec_ram.sv
rtl/slec_front.sv
rtl/slec_queue.sv
rtl/slec_back.sv
rtl/sequential_list_engine_core.sv
verif/tb_sequential_list_engine_core.sv
